// ----- hdl/sst_pkg.sv -----
// sst_pkg: shared types and constants of the sparse-set membership table
// no dependencies; imported by the interfaces, the sequencer and the top level
package sst_pkg;

  localparam int ID_W       = 8;   // entity id width
  localparam int SLOT_W     = 8;   // slot fields on the result channel
  localparam int CNT_OUT_W  = 9;   // live count on the result channel
  localparam int LIMIT_W    = 9;   // entity_limit register width
  localparam int MAX_IDS    = 256; // ids are ID_W bits wide

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_PRESENT = 2'd1,
    ST_REMOVED = 2'd2,
    ST_FAIL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_RESP
  } seq_state_t;

  typedef struct packed {
    status_t                status;
    logic [SLOT_W-1:0]      slot;
    logic                   moved;
    logic [SLOT_W-1:0]      moved_from;
    logic [ID_W-1:0]        moved_entity;
    logic [CNT_OUT_W-1:0]   live_count;
  } result_t;

endpackage

// ----- hdl/sst_if.sv -----
// sst_if: valid/ready channel interfaces for requests and results
// depends on sst_pkg
interface sst_in_if;
  import sst_pkg::*;

  logic            valid;
  logic            ready;
  logic            action;
  logic [ID_W-1:0] entity_id;

  modport source (output valid, action, entity_id, input ready);
  modport sink   (input valid, action, entity_id, output ready);
endinterface

interface sst_out_if;
  import sst_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [SLOT_W-1:0]    slot;
  logic                 moved;
  logic [SLOT_W-1:0]    moved_from;
  logic [ID_W-1:0]      moved_entity;
  logic [CNT_OUT_W-1:0] live_count;

  modport source (output valid, status, slot, moved, moved_from, moved_entity, live_count,
                  input ready);
  modport sink   (input valid, status, slot, moved, moved_from, moved_entity, live_count,
                  output ready);
endinterface

// ----- hdl/sst_ram.sv -----
// sst_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/sst_seq.sv -----
// sst_seq: sequencer of the table, owns the sparse and dense rams, valid bits and count
// depends on sst_pkg, sst_if and sst_ram
module sst_seq #(
  parameter int ENTITY_SLOTS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [sst_pkg::LIMIT_W-1:0]  limit,
  sst_in_if.sink                       in_ch,
  output logic                         res_valid,
  input  logic                         res_ready,
  output sst_pkg::result_t             res
);
  import sst_pkg::*;

  // only ID_W-bit ids exist, so neither ram needs more rows than that
  localparam int ENT_DEPTH = (ENTITY_SLOTS < MAX_IDS) ? ENTITY_SLOTS : MAX_IDS;
  localparam int AW        = $clog2(ENT_DEPTH);
  localparam int CNT_W     = $clog2(ENT_DEPTH + 1);
  localparam logic [LIMIT_W-1:0] DEPTH_LIM = LIMIT_W'(ENT_DEPTH);
  localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(ENT_DEPTH);

  seq_state_t           state_r, state_nxt;
  logic                 action_r, action_nxt;
  logic [ID_W-1:0]      ent_r, ent_nxt;
  logic                 reject_r, reject_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ENT_DEPTH-1:0] valid_r, valid_nxt;
  result_t              res_r, res_nxt;

  logic [LIMIT_W-1:0]   eff_lim;
  logic [CNT_W-1:0]     last_cnt;
  logic [AW-1:0]        last_slot;
  logic [AW-1:0]        ent_idx;
  logic                 ent_valid;

  logic                 sp_we, dn_we;
  logic [AW-1:0]        sp_waddr, sp_wdata, sp_raddr, sp_rdata;
  logic [AW-1:0]        dn_waddr, dn_wdata, dn_raddr, dn_rdata;

  // sparse: entity -> slot, dense: slot -> entity
  sst_ram #(.WIDTH(AW), .DEPTH(ENT_DEPTH)) u_sparse (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  sst_ram #(.WIDTH(AW), .DEPTH(ENT_DEPTH)) u_dense (
    .clk   (clk),
    .we    (dn_we),
    .waddr (dn_waddr),
    .wdata (dn_wdata),
    .raddr (dn_raddr),
    .rdata (dn_rdata)
  );

  assign eff_lim   = (limit > DEPTH_LIM) ? DEPTH_LIM : limit;
  assign last_cnt  = count_r - CNT_W'(1);
  assign last_slot = last_cnt[AW-1:0];
  assign ent_idx   = ent_r[AW-1:0];
  assign ent_valid = valid_r[ent_idx];

  assign sp_raddr  = in_ch.entity_id[AW-1:0];
  assign dn_raddr  = last_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    ent_r    <= ent_nxt;
    reject_r <= reject_nxt;
    res_r    <= res_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    action_nxt  = action_r;
    ent_nxt     = ent_r;
    reject_nxt  = reject_r;
    count_nxt   = count_r;
    valid_nxt   = valid_r;
    res_nxt     = res_r;
    in_ch.ready = 1'b0;
    res_valid   = 1'b0;
    sp_we       = 1'b0;
    sp_waddr    = ent_idx;
    sp_wdata    = count_r[AW-1:0];
    dn_we       = 1'b0;
    dn_waddr    = count_r[AW-1:0];
    dn_wdata    = ent_idx;

    case (state_r)
      S_IDLE: begin
        // the sparse ram is addressed straight from the request, the dense ram from the last slot, data back next cycle
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          action_nxt = in_ch.action;
          ent_nxt    = in_ch.entity_id;
          reject_nxt = LIMIT_W'(in_ch.entity_id) >= eff_lim;
          state_nxt  = S_LOOK;
        end
      end

      S_LOOK: begin
        res_nxt        = '0;
        res_nxt.status = ST_FAIL;
        if (!reject_r) begin
          if (!action_r) begin
            if (ent_valid) begin
              res_nxt.status = ST_PRESENT;
              res_nxt.slot   = SLOT_W'(sp_rdata);
            end else if (count_r < CNT_MAX) begin
              // append at the end of the dense list
              sp_we              = 1'b1;
              dn_we              = 1'b1;
              valid_nxt[ent_idx] = 1'b1;
              count_nxt          = count_r + CNT_W'(1);
              res_nxt.status     = ST_ADDED;
              res_nxt.slot       = SLOT_W'(count_r[AW-1:0]);
            end
          end else if (ent_valid && count_r != '0) begin
            // swap-and-pop: last entry fills the hole
            if (sp_rdata != last_slot) begin
              dn_we                = 1'b1;
              dn_waddr             = sp_rdata;
              dn_wdata             = dn_rdata;
              sp_we                = 1'b1;
              sp_waddr             = dn_rdata;
              sp_wdata             = sp_rdata;
              res_nxt.moved        = 1'b1;
              res_nxt.moved_from   = SLOT_W'(last_slot);
              res_nxt.moved_entity = ID_W'(dn_rdata);
            end
            valid_nxt[ent_idx] = 1'b0;
            count_nxt          = last_cnt;
            res_nxt.status     = ST_REMOVED;
            res_nxt.slot       = SLOT_W'(sp_rdata);
          end
        end
        res_nxt.live_count = CNT_OUT_W'(count_nxt);
        state_nxt          = S_RESP;
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = res_r;

`ifndef NO_ASSERTIONS
  // every valid entity holds exactly one dense slot
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("live count differs from number of valid entities");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("live count above table depth");

  // ram writes only in the read-modify-write step
  a_write_in_look: assert property (@(posedge clk) disable iff (!rst_n)
    (sp_we || dn_we) |-> state_r == S_LOOK)
    else $error("ram write outside lookup step");

  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == S_LOOK)
    else $error("accepted transaction did not start lookup");

  // count moves by at most one per transaction
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOOK) |=> $stable(count_r))
    else $error("live count changed outside lookup step");
`endif

endmodule

// ----- hdl/sparse_set_table_top.sv -----
// sparse_set_table_top: sparse-set membership table with swap-and-pop removal
// depends on sst_pkg, sst_if and sst_seq (which holds the sst_ram instances)
//
// Each request transaction (add or remove of one entity id) passes these steps
// in the block: accept with the sparse and dense ram reads, a read-modify-write
// step in which the valid bits, the count and both rams are updated, and a
// hand-off into the output register. The next request is taken in the cycle
// after the hand-off, so no new request is taken before the last result is
// handed off; a stalled result holds the sequencer at the hand-off once the
// output register is full. Presence is kept in flip-flops that reset clears at
// once, so there is no clearing pass after reset. On a remove that moves an
// entry, the result names the former slot and the entity so that an external
// data row can follow. The user must write entity_limit through cfg_we/cfg_wdata
// only while no transaction is in flight; the block itself does not enforce it.
module sparse_set_table_top #(
  parameter int ENTITY_SLOTS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sst_pkg::LIMIT_W-1:0] cfg_wdata,
  sst_in_if.sink                      in_ch,
  sst_out_if.source                   out_ch
);
  import sst_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic               out_valid_r;
  result_t            out_r;
  logic               res_valid;
  logic               res_ready;
  result_t            res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  sst_seq #(.ENTITY_SLOTS(ENTITY_SLOTS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register parts the sequencer from the result channel
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.slot         = out_r.slot;
  assign out_ch.moved        = out_r.moved;
  assign out_ch.moved_from   = out_r.moved_from;
  assign out_ch.moved_entity = out_r.moved_entity;
  assign out_ch.live_count   = out_r.live_count;

`ifndef NO_ASSERTIONS
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_r))
    else $error("pending result overwritten");

  a_handoff_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_valid_r)
    else $error("result lost at hand-off");

  // a failed transaction carries no slot and no move
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_FAIL) |-> (out_r.slot == '0 && !out_r.moved))
    else $error("failed transaction carries slot or move");
`endif

endmodule

// ----- verif/sparse_set_table_top_tb.sv -----
`timescale 1ns / 100ps
// sparse_set_table_top_tb: self-checking bench for the sparse-set membership table
// depends on sst_pkg, sst_if and the sparse_set_table_top rtl

module sparse_set_table_top_tb;
  import sst_pkg::*;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;
  localparam int   MAX_SHOWN  = 10;

  typedef struct packed {
    logic            action;
    logic [ID_W-1:0] entity_id;
  } request_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  sst_in_if  in_ch ();
  sst_out_if out_ch ();

  sparse_set_table_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // bench copy of the table
  logic [LIMIT_W-1:0] id_limit;
  bit                 occupied  [MAX_IDS];
  logic [SLOT_W-1:0]  slot_of   [MAX_IDS];
  logic [ID_W-1:0]    entity_at [MAX_IDS];
  int unsigned        live_n;

  request_t pending_q [$];
  result_t  expected_q[$];
  int       idle_pct;
  int       mismatch_n;
  int       in_gap;
  int       out_gap;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic result_t apply_request(request_t req);
    result_t         r;
    int unsigned     eff;
    int unsigned     hole;
    int unsigned     last;
    logic [ID_W-1:0] lent;
    r        = '0;
    r.status = ST_FAIL;
    eff      = (id_limit > MAX_IDS) ? MAX_IDS : 32'(id_limit);
    if (req.entity_id < eff) begin
      if (req.action == ACT_ADD) begin
        if (occupied[req.entity_id]) begin
          r.status = ST_PRESENT;
          r.slot   = slot_of[req.entity_id];
        end else begin
          occupied[req.entity_id] = 1'b1;
          slot_of[req.entity_id]  = SLOT_W'(live_n);
          entity_at[live_n]       = req.entity_id;
          r.status                = ST_ADDED;
          r.slot                  = SLOT_W'(live_n);
          live_n++;
        end
      end else if (occupied[req.entity_id] && live_n != 0) begin
        hole = 32'(slot_of[req.entity_id]);
        last = live_n - 1;
        // swap-and-pop: the last entry fills the hole
        if (hole != last) begin
          lent             = entity_at[last];
          entity_at[hole]  = lent;
          slot_of[lent]    = SLOT_W'(hole);
          r.moved          = 1'b1;
          r.moved_from     = SLOT_W'(last);
          r.moved_entity   = lent;
        end
        occupied[req.entity_id] = 1'b0;
        slot_of[req.entity_id]  = '0;
        live_n                  = last;
        r.status                = ST_REMOVED;
        r.slot                  = SLOT_W'(hole);
      end
    end
    r.live_count = CNT_OUT_W'(live_n);
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin : drive_requests
    request_t req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap      <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(apply_request({in_ch.action, in_ch.entity_id}));
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_ch.valid <= 1'b0;
          in_gap      <= in_gap - 1;
        end else if (pending_q.size() != 0) begin
          req              = pending_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.action    <= req.action;
          in_ch.entity_id <= req.entity_id;
          if ($urandom_range(0, 99) < idle_pct)
            in_gap <= $urandom_range(1, 17);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap      <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          mismatch_n++;
          if (mismatch_n <= MAX_SHOWN)
            $display("unexpected result transaction: status %0d slot %0d count %0d",
                     out_ch.status, out_ch.slot, out_ch.live_count);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.status !== want.status || out_ch.slot !== want.slot ||
              out_ch.moved !== want.moved || out_ch.moved_from !== want.moved_from ||
              out_ch.moved_entity !== want.moved_entity ||
              out_ch.live_count !== want.live_count) begin
            mismatch_n++;
            if (mismatch_n <= MAX_SHOWN) begin
              $display("result mismatch: expected status %0d slot %0d moved %0d/%0d/%0d count %0d",
                       want.status, want.slot, want.moved, want.moved_from,
                       want.moved_entity, want.live_count);
              $display("                 got      status %0d slot %0d moved %0d/%0d/%0d count %0d",
                       out_ch.status, out_ch.slot, out_ch.moved, out_ch.moved_from,
                       out_ch.moved_entity, out_ch.live_count);
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_ch.ready <= 1'b0;
        out_gap      <= out_gap - 1;
      end else if ($urandom_range(0, 299) < idle_pct) begin
        out_ch.ready <= 1'b0;
        out_gap      <= $urandom_range(0, 16);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_req(logic act, int unsigned id);
    pending_q.push_back('{action: act, entity_id: ID_W'(id)});
  endtask

  // every id once in random order, with repeats of ids already visited
  task automatic queue_sweep(logic act);
    int unsigned perm [MAX_IDS];
    int unsigned j;
    int unsigned t;
    for (int i = 0; i < MAX_IDS; i++) perm[i] = i;
    for (int i = MAX_IDS - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < MAX_IDS; i++) begin
      queue_req(act, perm[i]);
      if ($urandom_range(0, 7) == 0) queue_req(act, perm[$urandom_range(0, i)]);
    end
  endtask

  task automatic queue_mixed(int n, int add_pct, int unsigned id_hi);
    for (int i = 0; i < n; i++)
      queue_req(($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_REMOVE,
                $urandom_range(0, id_hi));
  endtask

  // hold off until every transaction has come back, then let the block settle
  task automatic wait_all_done();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_ch.valid || expected_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    id_limit   = value;
    @(negedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("FAIL sparse_set_table_top");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = LIMIT_RESET;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_ADD;
    in_ch.entity_id = '0;
    out_ch.ready    = 1'b0;
    id_limit        = LIMIT_RESET;
    live_n          = 0;
    idle_pct        = 20;
    mismatch_n      = 0;
    for (int i = 0; i < MAX_IDS; i++) begin
      occupied[i]  = 1'b0;
      slot_of[i]   = '0;
      entity_at[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, re-add, moves, removal of the last entry
    write_limit(LIMIT_RESET);
    queue_req(ACT_REMOVE, 0);
    queue_req(ACT_ADD, 0);
    queue_req(ACT_ADD, 0);
    queue_req(ACT_ADD, 255);
    queue_req(ACT_ADD, 128);
    queue_req(ACT_ADD, 85);
    queue_req(ACT_ADD, 170);
    queue_req(ACT_REMOVE, 0);
    queue_req(ACT_REMOVE, 85);
    queue_req(ACT_ADD, 7);
    queue_req(ACT_REMOVE, 255);
    queue_req(ACT_REMOVE, 0);
    wait_all_done();

    // smallest limits; live ids at or above the limit stay counted but out of reach
    write_limit(9'd1);
    queue_req(ACT_ADD, 0);
    queue_req(ACT_ADD, 1);
    queue_req(ACT_REMOVE, 255);
    wait_all_done();
    write_limit(9'd0);
    queue_req(ACT_ADD, 0);
    queue_req(ACT_REMOVE, 0);
    wait_all_done();
    write_limit(9'h1FF);
    queue_req(ACT_REMOVE, 255);
    queue_req(ACT_ADD, 255);
    queue_req(ACT_REMOVE, 0);
    wait_all_done();

    // fill the whole table, churn it from full, then empty it
    write_limit(LIMIT_RESET);
    idle_pct = 15;
    queue_sweep(ACT_ADD);
    wait_all_done();
    queue_mixed(150, 50, MAX_IDS - 1);
    queue_sweep(ACT_REMOVE);
    wait_all_done();

    write_limit(9'd100);
    idle_pct = 30;
    queue_mixed(120, 75, 127);
    queue_mixed(130, 40, 127);
    wait_all_done();

    // lower the limit under live entities
    write_limit(9'd200);
    idle_pct = 0;
    queue_mixed(100, 80, MAX_IDS - 1);
    wait_all_done();
    write_limit(9'd37);
    idle_pct = 25;
    queue_mixed(150, 50, 63);
    wait_all_done();

    // closing stretch with no idling on either side
    write_limit(9'h1FF);
    idle_pct = 0;
    queue_mixed(200, 50, MAX_IDS - 1);
    wait_all_done();
    repeat (8) @(negedge clk);

    if (mismatch_n == 0 && expected_q.size() == 0) begin
      $display("PASS sparse_set_table_top");
    end else begin
      $display("FAIL sparse_set_table_top");
    end
    $finish;
  end

endmodule
